// File: rtl/btb_pkg.sv
// ----------------------------------------------------------------------------
// btb_pkg
// Shared types, constants and codes of the branch target buffer.
// ----------------------------------------------------------------------------
package btb_pkg;

  localparam int unsigned WAYS       = 4;
  localparam int unsigned INDEX_BITS = 9;
  localparam int unsigned SETS       = 1 << INDEX_BITS;
  localparam int unsigned TAG_BITS   = 23;
  localparam int unsigned WAY_BITS   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned AGE_BITS   = 2;
  localparam logic [AGE_BITS-1:0] AGE_MAX = 2'h3;
  localparam logic [31:0] PC_STEP    = 32'd4;

  typedef enum logic {
    KIND_PREDICT = 1'b0,
    KIND_UPDATE  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    BR_JUMP     = 2'd0,
    BR_CALL     = 2'd1,
    BR_RETURN   = 2'd2,
    BR_INDIRECT = 2'd3
  } br_type_e;

  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_PUSH       = 3'd1,
    ACT_POP        = 3'd2,
    ACT_TC_PREDICT = 3'd3,
    ACT_TC_UPDATE  = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP
  } state_e;

  typedef struct packed {
    logic        kind;
    logic [31:0] pc;
    logic [31:0] target;
    logic [1:0]  branch_type;
  } req_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        hit;
    logic [2:0]  action;
    logic [31:0] return_address;
    logic [1:0]  way_used;
  } rsp_t;

  typedef struct packed {
    logic [TAG_BITS-1:0] tag;
    logic [31:0]         target;
    logic [1:0]          btype;
  } entry_t;

  typedef entry_t [WAYS-1:0] row_t;

  typedef struct packed {
    logic [WAYS-1:0]                valid;
    logic [WAYS-1:0][AGE_BITS-1:0]  age;
  } meta_t;

  typedef struct packed {
    rsp_t  rsp;
    row_t  row;
    meta_t meta;
    logic  wr_row;
    logic  wr_meta;
  } sel_t;

endpackage

// File: rtl/btb_ram.sv
// ----------------------------------------------------------------------------
// btb_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module btb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [ADDR_BITS-1:0] waddr_i,
  input  logic [WIDTH-1:0]     wdata_i,
  input  logic [ADDR_BITS-1:0] raddr_i,
  output logic [WIDTH-1:0]     rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/btb_sel.sv
// ----------------------------------------------------------------------------
// btb_sel
// Tag compare, way choice, age update and response for one set row.
// ----------------------------------------------------------------------------
module btb_sel import btb_pkg::*; (
  input  req_t  req_i,
  input  row_t  row_i,
  input  meta_t meta_i,
  output sel_t  sel_o
);

  logic [TAG_BITS-1:0] tag;
  logic [31:0]         ret;
  logic [WAYS-1:0]     match;
  logic                found;
  logic [WAY_BITS-1:0] hit_way;
  logic                any_free;
  logic [WAY_BITS-1:0] free_way;
  logic [WAY_BITS-1:0] old_way;
  logic [AGE_BITS-1:0] max_age;
  logic [WAY_BITS-1:0] way;
  logic [AGE_BITS-1:0] cur_age;
  logic                touch;
  br_type_e            hit_type;

  assign tag = req_i.pc[INDEX_BITS +: TAG_BITS];
  assign ret = req_i.pc + PC_STEP;

  always_comb begin
    hit_way  = '0;
    free_way = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      match[i] = meta_i.valid[i] && (row_i[i].tag == tag);
      if (match[i]) begin
        hit_way = WAY_BITS'(i);
      end
      if (!meta_i.valid[i]) begin
        free_way = WAY_BITS'(i);
      end
    end
    found    = |match;
    any_free = ~&meta_i.valid;
  end

  always_comb begin
    max_age = '0;
    old_way = '0;
    for (int i = 0; i < WAYS; i++) begin
      if (meta_i.age[i] > max_age) begin
        max_age = meta_i.age[i];
        old_way = WAY_BITS'(i);
      end
    end
  end

  always_comb begin
    if (found) begin
      way = hit_way;
    end else if (req_i.kind == KIND_PREDICT) begin
      way = '0;
    end else if (any_free) begin
      way = free_way;
    end else begin
      way = old_way;
    end
  end

  assign touch    = (req_i.kind == KIND_UPDATE) || found;
  assign cur_age  = meta_i.age[way];
  assign hit_type = br_type_e'(row_i[hit_way].btype);

  always_comb begin
    sel_o.meta = meta_i;
    for (int i = 0; i < WAYS; i++) begin
      if (WAY_BITS'(i) == way) begin
        sel_o.meta.age[i] = '0;
      end else if (meta_i.age[i] <= cur_age && meta_i.age[i] != AGE_MAX) begin
        sel_o.meta.age[i] = meta_i.age[i] + 1'b1;
      end
    end
    if (req_i.kind == KIND_UPDATE) begin
      sel_o.meta.valid[way] = 1'b1;
    end
    sel_o.wr_meta = touch;

    sel_o.row = row_i;
    sel_o.row[way].target = req_i.target;
    sel_o.row[way].btype  = req_i.branch_type;
    if (!found) begin
      sel_o.row[way].tag = tag;
    end
    sel_o.wr_row = (req_i.kind == KIND_UPDATE);

    sel_o.rsp.hit            = found;
    sel_o.rsp.return_address = ret;
    sel_o.rsp.way_used       = 2'(way);
    sel_o.rsp.next_pc        = ret;
    sel_o.rsp.action         = ACT_NONE;
    if (req_i.kind == KIND_UPDATE) begin
      sel_o.rsp.next_pc = req_i.target;
      if (br_type_e'(req_i.branch_type) == BR_INDIRECT) begin
        sel_o.rsp.action = ACT_TC_UPDATE;
      end
    end else if (found) begin
      case (hit_type)
        BR_JUMP: begin
          sel_o.rsp.next_pc = row_i[hit_way].target;
        end
        BR_CALL: begin
          sel_o.rsp.next_pc = row_i[hit_way].target;
          sel_o.rsp.action  = ACT_PUSH;
        end
        BR_RETURN: begin
          sel_o.rsp.action = ACT_POP;
        end
        BR_INDIRECT: begin
          sel_o.rsp.next_pc = row_i[hit_way].target;
          sel_o.rsp.action  = ACT_TC_PREDICT;
        end
        default: begin
          sel_o.rsp.action = ACT_NONE;
        end
      endcase
    end
  end

endmodule

// File: rtl/branch_target_buffer_lru.sv
// ----------------------------------------------------------------------------
// branch_target_buffer_lru
// Set-associative branch target buffer with saturating age replacement.
// ----------------------------------------------------------------------------
// Each word is accepted when start is high and busy is low. The set row and
// its valid/age bits are read from RAM at acceptance, then compared, modified
// and written back in the following cycle, and busy stays high until that
// write-back is done. The result is registered into rsp_o in the lookup cycle
// and done_o rises with it for a single cycle; it cannot be held off. After
// reset the valid/age RAM is cleared one set per cycle, and busy stays high
// until every set is cleared.
module branch_target_buffer_lru import btb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output rsp_t rsp_o,
  output logic done_o
);

  state_e                state_q, state_d;
  logic [INDEX_BITS-1:0] clr_q, clr_d;
  req_t                  req_q;
  rsp_t                  rsp_q;
  logic                  done_q;
  logic                  accept;
  row_t                  row_rd;
  meta_t                 meta_rd;
  sel_t                  sel;
  logic                  row_we;
  logic                  meta_we;
  meta_t                 meta_wd;
  logic [INDEX_BITS-1:0] meta_waddr;
  logic [INDEX_BITS-1:0] set_q;

  assign set_q = req_q.pc[INDEX_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= (state_q == ST_LOOKUP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (state_q == ST_LOOKUP) begin
      rsp_q <= sel.rsp;
    end
  end

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    busy       = 1'b1;
    accept     = 1'b0;
    row_we     = 1'b0;
    meta_we    = 1'b0;
    meta_wd    = sel.meta;
    meta_waddr = set_q;
    case (state_q)
      ST_CLEAR: begin
        meta_we    = 1'b1;
        meta_wd    = '0;
        meta_waddr = clr_q;
        clr_d      = clr_q + 1'b1;
        if (clr_q == INDEX_BITS'(SETS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy   = 1'b0;
        accept = start;
        if (start) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        row_we  = sel.wr_row;
        meta_we = sel.wr_meta;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  btb_ram #(
    .WIDTH ($bits(row_t)),
    .DEPTH (SETS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (set_q),
    .wdata_i (sel.row),
    .raddr_i (req_i.pc[INDEX_BITS-1:0]),
    .rdata_o (row_rd)
  );

  btb_ram #(
    .WIDTH ($bits(meta_t)),
    .DEPTH (SETS)
  ) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wd),
    .raddr_i (req_i.pc[INDEX_BITS-1:0]),
    .rdata_o (meta_rd)
  );

  btb_sel u_sel (
    .req_i  (req_q),
    .row_i  (row_rd),
    .meta_i (meta_rd),
    .sel_o  (sel)
  );

  assign rsp_o  = rsp_q;
  assign done_o = done_q;

endmodule

// File: rtl/btb_checker.sv
// ----------------------------------------------------------------------------
// btb_props
// Port-level checks of the branch target buffer, bound to the top level.
// ----------------------------------------------------------------------------
module btb_props import btb_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input req_t req_i,
  input rsp_t rsp_o,
  input logic done_o
);

  logic acc;

  assign acc = start && !busy;

  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == $past(acc, 2))
    else $error("result strobe not two cycles after acceptance");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> busy)
    else $error("busy not raised after acceptance");

  a_return_address: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> rsp_o.return_address == $past(req_i.pc, 2) + PC_STEP)
    else $error("return address is not pc plus four");

  a_predict_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rsp_o.hit && $past(req_i.kind, 2) == KIND_PREDICT) |->
      (rsp_o.next_pc == rsp_o.return_address && rsp_o.action == ACT_NONE &&
       rsp_o.way_used == 2'd0))
    else $error("predict miss result malformed");

  a_update_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(req_i.kind, 2) == KIND_UPDATE) |->
      rsp_o.next_pc == $past(req_i.target, 2))
    else $error("update result does not echo target");

endmodule

bind branch_target_buffer_lru btb_props u_btb_props (.*);

// File: sim/btb_checker.sv
// ----------------------------------------------------------------------------
// btb_checker
// Watches the request and result channels of the branch target buffer. Keeps
// its own copy of the tag, target, type, valid and age state, works out the
// expected result of every accepted word and compares the results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module btb_checker import btb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  req_t        req_i,
  input  rsp_t        rsp_i,
  input  logic        done_i,
  output int unsigned errors_o,
  output int unsigned pending_o
);

  logic [TAG_BITS-1:0] tag_mem   [SETS][WAYS];
  logic [31:0]         tgt_mem   [SETS][WAYS];
  br_type_e            btype_mem [SETS][WAYS];
  logic                valid_mem [SETS][WAYS];
  logic [AGE_BITS-1:0] age_mem   [SETS][WAYS];

  rsp_t expected_q[$];

  function automatic void age_touch(int unsigned s, int unsigned w);
    logic [AGE_BITS-1:0] cur;
    cur = age_mem[s][w];
    for (int unsigned i = 0; i < WAYS; i++) begin
      if (i != w && age_mem[s][i] <= cur && age_mem[s][i] != AGE_MAX) begin
        age_mem[s][i] = age_mem[s][i] + 1'b1;
      end
    end
    age_mem[s][w] = '0;
  endfunction

  function automatic rsp_t lookup_or_write(req_t w);
    rsp_t                r;
    int unsigned         set_idx;
    logic [TAG_BITS-1:0] tag;
    logic [31:0]         ret;
    int unsigned         way;
    logic                found;
    logic                empty;
    logic [AGE_BITS-1:0] max_age;
    set_idx = w.pc[INDEX_BITS-1:0] % SETS;
    tag     = w.pc[INDEX_BITS +: TAG_BITS];
    ret     = w.pc + PC_STEP;
    way     = 0;
    found   = 1'b0;
    for (int unsigned i = 0; i < WAYS; i++) begin
      if (valid_mem[set_idx][i] && tag_mem[set_idx][i] == tag) begin
        found = 1'b1;
        way   = i;
        break;
      end
    end
    r                = '0;
    r.return_address = ret;
    r.next_pc        = ret;
    r.action         = ACT_NONE;
    if (w.kind == KIND_PREDICT) begin
      if (found) begin
        r.hit = 1'b1;
        age_touch(set_idx, way);
        case (btype_mem[set_idx][way])
          BR_JUMP: r.next_pc = tgt_mem[set_idx][way];
          BR_CALL: begin
            r.next_pc = tgt_mem[set_idx][way];
            r.action  = ACT_PUSH;
          end
          BR_RETURN: r.action = ACT_POP;
          default: begin
            r.next_pc = tgt_mem[set_idx][way];
            r.action  = ACT_TC_PREDICT;
          end
        endcase
      end else begin
        way = 0;
      end
    end else begin
      if (found) begin
        r.hit = 1'b1;
      end else begin
        empty = 1'b0;
        for (int unsigned i = 0; i < WAYS; i++) begin
          if (!valid_mem[set_idx][i]) begin
            way   = i;
            empty = 1'b1;
            break;
          end
        end
        if (!empty) begin
          max_age = '0;
          way     = 0;
          for (int unsigned i = 0; i < WAYS; i++) begin
            if (age_mem[set_idx][i] > max_age) begin
              max_age = age_mem[set_idx][i];
              way     = i;
            end
          end
        end
        valid_mem[set_idx][way] = 1'b1;
        tag_mem[set_idx][way]   = tag;
      end
      tgt_mem[set_idx][way]   = w.target;
      btype_mem[set_idx][way] = br_type_e'(w.branch_type);
      age_touch(set_idx, way);
      r.next_pc = w.target;
      r.action  = (w.branch_type == BR_INDIRECT) ? ACT_TC_UPDATE : ACT_NONE;
    end
    r.way_used = way[1:0];
    return r;
  endfunction

  function automatic int field_diff(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t exp;
    int   bad;
    if (!rst_ni) begin
      for (int s = 0; s < SETS; s++) begin
        for (int w = 0; w < WAYS; w++) begin
          valid_mem[s][w] = 1'b0;
          age_mem[s][w]   = '0;
        end
      end
      expected_q.delete();
      errors_o  = 0;
      pending_o = 0;
    end else begin
      if (done_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result word with nothing expected, actual %p", $time, rsp_i);
          errors_o++;
        end else begin
          exp = expected_q.pop_front();
          bad = field_diff("next_pc", exp.next_pc, rsp_i.next_pc)
              + field_diff("hit", 32'(exp.hit), 32'(rsp_i.hit))
              + field_diff("action", 32'(exp.action), 32'(rsp_i.action))
              + field_diff("return_address", exp.return_address, rsp_i.return_address)
              + field_diff("way_used", 32'(exp.way_used), 32'(rsp_i.way_used));
          if (bad != 0) errors_o++;
        end
      end
      if (start_i && !busy_i) begin
        expected_q.push_back(lookup_or_write(req_i));
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the branch target buffer with a directed sequence of fills, hits,
// evictions and wrap-around addresses, then with random lookups and updates
// concentrated on a few hot sets, under varying sender gaps. The checker
// beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import btb_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned PHASE_WORDS = 640;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  req_t        req;
  rsp_t        rsp;
  logic        done;
  int unsigned errors;
  int unsigned pending;
  int unsigned idle_pct;
  int unsigned stall_cnt;

  logic [INDEX_BITS-1:0] hot_set [4];
  logic [TAG_BITS-1:0]   hot_tag [6];

  branch_target_buffer_lru u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req),
    .rsp_o  (rsp),
    .done_o (done)
  );

  btb_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .busy_i    (busy),
    .req_i     (req),
    .rsp_i     (rsp),
    .done_i    (done),
    .errors_o  (errors),
    .pending_o (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || done) begin
      stall_cnt = 0;
    end else begin
      stall_cnt++;
    end
    if (stall_cnt >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [31:0] set_pc(logic [TAG_BITS-1:0] tag,
                                         logic [INDEX_BITS-1:0] set_idx);
    return {tag, set_idx};
  endfunction

  function automatic req_t make_word(kind_e k, logic [31:0] pc, logic [31:0] tgt,
                                     br_type_e bt);
    req_t w;
    w.kind        = k;
    w.pc          = pc;
    w.target      = tgt;
    w.branch_type = bt;
    return w;
  endfunction

  function automatic req_t random_word();
    logic [31:0] pc;
    if ($urandom_range(99) < 80) begin
      pc = set_pc(hot_tag[$urandom_range(5)], hot_set[$urandom_range(3)]);
    end else begin
      pc = $urandom;
    end
    return make_word(kind_e'($urandom_range(1)), pc, $urandom,
                     br_type_e'($urandom_range(3)));
  endfunction

  task automatic send_word(input req_t w);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req   <= w;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  initial begin
    stall_cnt = 0;
    idle_pct  = 0;
    rst_ni    = 1'b0;
    start     = 1'b0;
    req       = '0;
    foreach (hot_set[i]) hot_set[i] = INDEX_BITS'($urandom);
    foreach (hot_tag[i]) hot_tag[i] = TAG_BITS'($urandom);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_word(make_word(KIND_PREDICT, set_pc(23'd1, 9'd5), 32'h0, BR_JUMP));
    send_word(make_word(KIND_UPDATE, set_pc(23'd1, 9'd5), 32'hFFFF_FFFF, BR_JUMP));
    send_word(make_word(KIND_PREDICT, set_pc(23'd1, 9'd5), 32'h0, BR_JUMP));
    send_word(make_word(KIND_UPDATE, set_pc(23'd2, 9'd5), 32'h0, BR_CALL));
    send_word(make_word(KIND_PREDICT, set_pc(23'd2, 9'd5), 32'h0, BR_JUMP));
    send_word(make_word(KIND_UPDATE, set_pc(23'd3, 9'd5), 32'h1234_5678, BR_RETURN));
    send_word(make_word(KIND_PREDICT, set_pc(23'd3, 9'd5), 32'h0, BR_JUMP));
    send_word(make_word(KIND_UPDATE, set_pc(23'd4, 9'd5), 32'hA5A5_A5A4, BR_INDIRECT));
    send_word(make_word(KIND_PREDICT, set_pc(23'd4, 9'd5), 32'h0, BR_JUMP));
    send_word(make_word(KIND_UPDATE, set_pc(23'd5, 9'd5), 32'h0000_1000, BR_JUMP));
    send_word(make_word(KIND_PREDICT, set_pc(23'd1, 9'd5), 32'h0, BR_JUMP));
    send_word(make_word(KIND_UPDATE, set_pc(23'd2, 9'd5), 32'h5555_5554, BR_INDIRECT));
    send_word(make_word(KIND_PREDICT, set_pc(23'd2, 9'd5), 32'h0, BR_JUMP));
    send_word(make_word(KIND_UPDATE, 32'hFFFF_FFFF, 32'h5A5A_5A5A, BR_CALL));
    send_word(make_word(KIND_PREDICT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, BR_INDIRECT));
    send_word(make_word(KIND_PREDICT, 32'h0, 32'h0, BR_JUMP));
    send_word(make_word(KIND_UPDATE, 32'h0, 32'hFFFF_FFFC, BR_RETURN));
    send_word(make_word(KIND_PREDICT, 32'h0, 32'h0, BR_JUMP));
    send_word(make_word(KIND_UPDATE, set_pc(23'h7F_FFFF, 9'd5), 32'h8000_0000, BR_CALL));
    send_word(make_word(KIND_UPDATE, set_pc(23'd6, 9'd5), 32'h0000_0004, BR_JUMP));
    send_word(make_word(KIND_PREDICT, set_pc(23'd5, 9'd5), 32'h0, BR_JUMP));
    send_word(make_word(KIND_PREDICT, set_pc(23'h7F_FFFF, 9'd5), 32'h0, BR_JUMP));

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 7 : (phase == 1) ? 56 : 0;
      repeat (PHASE_WORDS) send_word(random_word());
    end
    start <= 1'b0;

    do @(negedge clk_i); while (pending != 0);
    repeat (6) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
